/* rtl/sfrg_pkg.sv */
package sfrg_pkg;

    localparam int FRAGMENT_PAYLOAD = 1024;
    localparam int MAX_FRAGMENTS    = 32;
    localparam int BUFFER_BYTES     = 4229;

    localparam int MASK_W = 32;
    localparam int SUM_W  = 17;
    localparam int LEN_W  = 13;

    typedef enum logic [2:0] {
        V_DROP     = 3'd0,
        V_HELLO    = 3'd1,
        V_RESEND   = 3'd2,
        V_REPLAY   = 3'd3,
        V_STORED   = 3'd4,
        V_COMPLETE = 3'd5
    } verdict_t;

    typedef struct packed {
        logic        packet_valid;
        logic [7:0]  opcode;
        logic [15:0] session_tag;
        logic [15:0] req_id;
        logic [4:0]  frag_index;
        logic [5:0]  frag_count;
        logic [10:0] frag_length;
        logic [63:0] peer_mac_port;
        logic [31:0] peer_ip;
        logic [31:0] peer_nonce;
        logic [31:0] local_nonce;
    } req_t;

    typedef struct packed {
        logic [2:0]       verdict;
        logic [15:0]      current_session;
        logic [LEN_W-1:0] write_offset;
        logic [LEN_W-1:0] total_length;
        logic [7:0]       done_opcode;
        logic [15:0]      done_req_id;
    } res_t;

    typedef struct packed {
        logic     pass;
        verdict_t verdict;
    } sess_dec_t;

    typedef struct packed {
        verdict_t         verdict;
        logic             complete;
        logic [LEN_W-1:0] write_offset;
        logic [LEN_W-1:0] total_length;
        logic [7:0]       opcode;
        logic [15:0]      req_id;
    } asm_out_t;

endpackage

/* rtl/sfrg_req_if.sv */
interface sfrg_req_if import sfrg_pkg::*;
();
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/sfrg_res_if.sv */
interface sfrg_res_if import sfrg_pkg::*;
();
    logic valid;
    logic ready;
    res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/sfrg_session.sv */
module sfrg_session import sfrg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [7:0]  cfg_data,
    input  logic        fire,
    input  req_t        item,
    input  logic        complete,
    output sess_dec_t   dec,
    output logic [15:0] cur_session
);

    logic [7:0]  hello_op_reg;
    logic        open_reg;
    logic [15:0] session_reg;
    logic [63:0] mac_reg;
    logic [31:0] ip_reg;
    logic        ans_valid_reg;
    logic [15:0] ans_id_reg;

    logic        is_hello;
    logic        hello_ok;
    logic [15:0] sid_raw;
    logic [15:0] sid;
    logic        bound_ok;
    logic [15:0] id_diff;
    logic        id_newer;

    assign is_hello = item.packet_valid && item.opcode == hello_op_reg
                      && item.session_tag == 16'd0;
    assign hello_ok = is_hello && item.frag_length == 11'd4 && item.frag_count == 6'd1;
    assign sid_raw  = item.peer_nonce[15:0] ^ item.local_nonce[15:0];
    assign sid      = (sid_raw == 16'd0) ? 16'd1 : sid_raw;
    assign bound_ok = open_reg && item.session_tag == session_reg
                      && item.peer_mac_port == mac_reg && item.peer_ip == ip_reg;
    assign id_diff  = item.req_id - ans_id_reg;
    assign id_newer = id_diff != 16'd0 && !id_diff[15];

    assign cur_session = hello_ok ? sid : session_reg;

    always_comb
    begin
        dec.pass    = 1'b0;
        dec.verdict = V_DROP;
        if (!item.packet_valid || (is_hello && !hello_ok))
        begin
            dec.verdict = V_DROP;
        end
        else if (hello_ok)
        begin
            dec.verdict = V_HELLO;
        end
        else if (!bound_ok)
        begin
            dec.verdict = V_DROP;
        end
        else if (ans_valid_reg && item.req_id == ans_id_reg)
        begin
            dec.verdict = V_RESEND;
        end
        else if (ans_valid_reg && !id_newer)
        begin
            dec.verdict = V_REPLAY;
        end
        else
        begin
            dec.pass = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hello_op_reg  <= 8'd1;
            open_reg      <= 1'b0;
            session_reg   <= '0;
            mac_reg       <= '0;
            ip_reg        <= '0;
            ans_valid_reg <= 1'b0;
            ans_id_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                hello_op_reg <= cfg_data;
            end
            if (fire && hello_ok)
            begin
                open_reg      <= 1'b1;
                session_reg   <= sid;
                mac_reg       <= item.peer_mac_port;
                ip_reg        <= item.peer_ip;
                ans_valid_reg <= 1'b0;
            end
            else if (fire && dec.pass && complete)
            begin
                ans_valid_reg <= 1'b1;
                ans_id_reg    <= item.req_id;
            end
        end
    end

endmodule

/* rtl/sfrg_assembly.sv */
module sfrg_assembly import sfrg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     update,
    input  req_t     item,
    output asm_out_t asm_out
);

    logic [15:0]       id_reg;
    logic [5:0]        count_reg;
    logic [7:0]        op_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] full_reg;
    logic [10:0]       last_len_reg;

    logic              restart;
    logic [5:0]        eff_count;
    logic [7:0]        eff_op;
    logic [MASK_W-1:0] eff_mask;
    logic [MASK_W-1:0] eff_full;
    logic [SUM_W-1:0]  offset;
    logic [SUM_W-1:0]  end_pos;
    logic              bad;
    logic [MASK_W-1:0] frag_bit;
    logic [MASK_W-1:0] mask_next;
    logic [MASK_W-1:0] full_next;
    logic [MASK_W-1:0] expected;
    logic [4:0]        last_idx;
    logic [MASK_W-1:0] need_full;
    logic              all_full;
    logic [10:0]       last_size;
    logic [SUM_W-1:0]  total;
    logic              complete;

    assign restart   = item.req_id != id_reg;
    assign eff_count = restart ? item.frag_count : count_reg;
    assign eff_op    = restart ? item.opcode : op_reg;
    assign eff_mask  = restart ? '0 : mask_reg;
    assign eff_full  = restart ? '0 : full_reg;

    assign offset  = SUM_W'(item.frag_index) * SUM_W'(FRAGMENT_PAYLOAD);
    assign end_pos = offset + SUM_W'(item.frag_length);
    assign bad     = item.frag_count != eff_count || item.opcode != eff_op
                     || {1'b0, item.frag_index} >= 6'(MAX_FRAGMENTS)
                     || item.frag_count > 6'(MAX_FRAGMENTS)
                     || end_pos > SUM_W'(BUFFER_BYTES);

    assign frag_bit  = MASK_W'(1) << item.frag_index;
    assign mask_next = eff_mask | frag_bit;
    assign full_next = (item.frag_length == 11'(FRAGMENT_PAYLOAD)) ? (eff_full | frag_bit)
                                                                    : (eff_full & ~frag_bit);
    assign expected  = (eff_count >= 6'(MASK_W)) ? '1
                                                 : (MASK_W'(1) << eff_count[4:0]) - MASK_W'(1);
    assign last_idx  = eff_count[4:0] - 5'd1;
    assign need_full = (MASK_W'(1) << last_idx) - MASK_W'(1);
    assign all_full  = &(full_next | ~need_full);
    assign last_size = (item.frag_index == last_idx) ? item.frag_length : last_len_reg;
    assign total     = SUM_W'(last_idx) * SUM_W'(FRAGMENT_PAYLOAD) + SUM_W'(last_size);
    assign complete  = !bad && eff_count != 6'd0 && mask_next == expected && all_full;

    always_comb
    begin
        asm_out.complete     = complete;
        asm_out.verdict      = V_DROP;
        asm_out.write_offset = '0;
        asm_out.total_length = '0;
        asm_out.opcode       = '0;
        asm_out.req_id       = '0;
        if (!bad)
        begin
            asm_out.verdict      = complete ? V_COMPLETE : V_STORED;
            asm_out.write_offset = offset[LEN_W-1:0];
            asm_out.total_length = complete ? total[LEN_W-1:0] : '0;
            asm_out.opcode       = eff_op;
            asm_out.req_id       = item.req_id;
        end
    end

    // last fragment length is only read once its mask bit is set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg       <= '0;
            count_reg    <= '0;
            op_reg       <= '0;
            mask_reg     <= '0;
            full_reg     <= '0;
            last_len_reg <= '0;
        end
        else if (update)
        begin
            if (restart)
            begin
                id_reg    <= item.req_id;
                count_reg <= item.frag_count;
                op_reg    <= item.opcode;
            end
            if (!bad)
            begin
                mask_reg <= mask_next;
                full_reg <= full_next;
                if (item.frag_index == last_idx)
                begin
                    last_len_reg <= item.frag_length;
                end
            end
            else if (restart)
            begin
                mask_reg <= '0;
                full_reg <= '0;
            end
        end
    end

endmodule

/* rtl/session_fragment_reassembly_gate.sv */
// a request is held in the input register, then its result in the result register
// throughput: one request per cycle unless stalled; session and assembly update only on fire
// stalls only when both registers hold a request and the result is not being taken
// reset: session closed, answered mark cleared, assembly state and mask cleared
// reset: hello opcode register returns to 1
module session_fragment_reassembly_gate import sfrg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [7:0] cfg_data,
    sfrg_req_if.sink   req,
    sfrg_res_if.source res
);

    req_t      s1_reg;
    logic      s1_valid_reg;
    res_t      res_reg;
    logic      res_valid_reg;
    res_t      res_next;

    logic      advance;
    logic      fire;
    sess_dec_t dec;
    asm_out_t  asm_out;
    logic [15:0] cur_session;

    assign advance   = !res_valid_reg || res.ready;
    assign fire      = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;
    assign res.valid   = res_valid_reg;
    assign res.payload = res_reg;

    sfrg_session u_session
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .fire        (fire),
        .item        (s1_reg),
        .complete    (asm_out.complete),
        .dec         (dec),
        .cur_session (cur_session)
    );

    sfrg_assembly u_assembly
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .update  (fire && dec.pass),
        .item    (s1_reg),
        .asm_out (asm_out)
    );

    always_comb
    begin
        res_next.current_session = cur_session;
        if (dec.pass)
        begin
            res_next.verdict      = asm_out.verdict;
            res_next.write_offset = asm_out.write_offset;
            res_next.total_length = asm_out.total_length;
            res_next.done_opcode  = asm_out.opcode;
            res_next.done_req_id  = asm_out.req_id;
        end
        else
        begin
            res_next.verdict      = dec.verdict;
            res_next.write_offset = '0;
            res_next.total_length = '0;
            res_next.done_opcode  = (dec.verdict == V_DROP) ? 8'd0 : s1_reg.opcode;
            res_next.done_req_id  = (dec.verdict == V_DROP) ? 16'd0 : s1_reg.req_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (advance)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_reg <= req.payload;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    a_total_only_complete: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.payload.verdict != V_COMPLETE |-> res.payload.total_length == '0)
        else $error("total length set on a result that is not complete");

    a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.payload.verdict == V_DROP |->
            res.payload.done_opcode == 8'd0 && res.payload.done_req_id == 16'd0
            && res.payload.write_offset == '0)
        else $error("dropped request carries payload fields");

    a_assembly_needs_session: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.payload.verdict == V_STORED || res.payload.verdict == V_COMPLETE)
            |-> res.payload.current_session != 16'd0)
        else $error("fragment accepted without an open session");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_reg))
        else $error("held request lost while result register stalled");

endmodule

/* sim/tb_session_fragment_reassembly_gate.sv */
module tb_session_fragment_reassembly_gate;
    import sfrg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 63;
    localparam logic [63:0] HOME_MAC = 64'h0123_4567_89AB_CDEF;
    localparam logic [31:0] HOME_IP  = 32'hC0A8_0001;

    class reassembly_scoreboard;
        logic [7:0]  hello_op;
        bit          sess_open;
        logic [15:0] sess_id;
        logic [63:0] peer_mac;
        logic [31:0] peer_addr;
        bit          last_answer_valid;
        logic [15:0] last_answer_id;
        logic [15:0] asm_id;
        logic [5:0]  asm_count;
        logic [7:0]  asm_op;
        logic [31:0] frag_mask;
        logic [10:0] frag_len [32];
        res_t        expected_results [$];
        int          errors;

        function new();
            hello_op = 8'd1;
            sess_open = 0;
            sess_id = '0;
            peer_mac = '0;
            peer_addr = '0;
            last_answer_valid = 0;
            last_answer_id = '0;
            asm_id = '0;
            asm_count = '0;
            asm_op = '0;
            frag_mask = '0;
            foreach (frag_len[i]) frag_len[i] = '0;
            errors = 0;
        endfunction

        function res_t predict_verdict(req_t r);
            res_t        o;
            logic [15:0] sid;
            logic [15:0] gap;
            logic [31:0] full;
            int          offs;
            int          total;
            o = '0;
            o.verdict = V_DROP;
            o.current_session = sess_id;
            if (!r.packet_valid)
                return o;
            if (r.opcode == hello_op && r.session_tag == 16'h0)
            begin
                if (r.frag_length != 11'd4 || r.frag_count != 6'd1)
                    return o;
                sid = r.peer_nonce[15:0] ^ r.local_nonce[15:0];
                if (sid == 16'h0)
                    sid = 16'h1;
                sess_id = sid;
                peer_mac = r.peer_mac_port;
                peer_addr = r.peer_ip;
                sess_open = 1;
                last_answer_valid = 0;
                o.verdict = V_HELLO;
                o.current_session = sid;
                o.done_opcode = r.opcode;
                o.done_req_id = r.req_id;
                return o;
            end
            if (!sess_open || r.session_tag != sess_id || r.peer_mac_port != peer_mac
                || r.peer_ip != peer_addr)
                return o;
            if (last_answer_valid && r.req_id == last_answer_id)
            begin
                o.verdict = V_RESEND;
                o.done_opcode = r.opcode;
                o.done_req_id = r.req_id;
                return o;
            end
            gap = r.req_id - last_answer_id;
            if (last_answer_valid && !(gap != 16'h0 && gap < 16'h8000))
            begin
                o.verdict = V_REPLAY;
                o.done_opcode = r.opcode;
                o.done_req_id = r.req_id;
                return o;
            end
            if (r.req_id != asm_id)
            begin
                asm_id = r.req_id;
                asm_count = r.frag_count;
                asm_op = r.opcode;
                frag_mask = '0;
                foreach (frag_len[i]) frag_len[i] = '0;
            end
            offs = int'(r.frag_index) * FRAGMENT_PAYLOAD;
            if (r.frag_count != asm_count || r.opcode != asm_op
                || int'(r.frag_index) >= MAX_FRAGMENTS || int'(r.frag_count) > MAX_FRAGMENTS
                || offs + int'(r.frag_length) > BUFFER_BYTES)
                return o;
            frag_len[r.frag_index] = r.frag_length;
            frag_mask = frag_mask | (32'h1 << r.frag_index);
            o.verdict = V_STORED;
            o.write_offset = LEN_W'(offs);
            o.done_opcode = asm_op;
            o.done_req_id = asm_id;
            full = (asm_count >= 6'd32) ? 32'hFFFF_FFFF : ((32'h1 << asm_count) - 32'h1);
            if (asm_count == 6'd0 || frag_mask != full)
                return o;
            for (int i = 0; i + 1 < int'(asm_count); i++)
            begin
                if (int'(frag_len[i]) != FRAGMENT_PAYLOAD)
                    return o;
            end
            total = (int'(asm_count) - 1) * FRAGMENT_PAYLOAD + int'(frag_len[asm_count - 6'd1]);
            last_answer_valid = 1;
            last_answer_id = asm_id;
            o.verdict = V_COMPLETE;
            o.total_length = LEN_W'(total);
            return o;
        endfunction

        function void note_request(req_t r);
            expected_results.push_back(predict_verdict(r));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual verdict %0d session %0h",
                         $time, got.verdict, got.current_session);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("verdict", want.verdict, got.verdict);
            compare_field("current_session", want.current_session, got.current_session);
            compare_field("write_offset", want.write_offset, got.write_offset);
            compare_field("total_length", want.total_length, got.total_length);
            compare_field("done_opcode", want.done_opcode, got.done_opcode);
            compare_field("done_req_id", want.done_req_id, got.done_req_id);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [7:0] cfg_data;

    sfrg_req_if req_ch ();
    sfrg_res_if res_ch ();

    session_fragment_reassembly_gate uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    reassembly_scoreboard sb;
    int src_idle_pct;
    int sink_stall_pct;
    int items_sent;
    int idle_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            sb.check_result(res_ch.payload);
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            || (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic req_t mk_req(logic v, logic [7:0] op, logic [15:0] tag,
                                    logic [15:0] rid, logic [4:0] idx, logic [5:0] cnt,
                                    logic [10:0] len, logic [63:0] mac, logic [31:0] ip,
                                    logic [31:0] cn, logic [31:0] sn);
        req_t r;
        r.packet_valid = v;
        r.opcode = op;
        r.session_tag = tag;
        r.req_id = rid;
        r.frag_index = idx;
        r.frag_count = cnt;
        r.frag_length = len;
        r.peer_mac_port = mac;
        r.peer_ip = ip;
        r.peer_nonce = cn;
        r.local_nonce = sn;
        return r;
    endfunction

    task automatic send_request(input req_t item);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= item;
        @(posedge clk);
        while (req_ch.ready !== 1'b1) @(posedge clk);
        sb.note_request(item);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        req_ch.valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_hello_opcode(input logic [7:0] value);
        wait_results_drained();
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.hello_op = value;
    endtask

    task automatic send_hello(input logic [63:0] mac, input logic [31:0] ip,
                              input logic [31:0] cn, input logic [31:0] sn,
                              input logic [10:0] len, input logic [5:0] cnt);
        send_request(mk_req(1'b1, sb.hello_op, 16'h0, 16'($urandom), 5'($urandom), cnt, len,
                            mac, ip, cn, sn));
    endtask

    task automatic send_frag(input logic [7:0] op, input logic [15:0] rid,
                             input logic [4:0] idx, input logic [5:0] cnt,
                             input logic [10:0] len);
        send_request(mk_req(1'b1, op, sb.sess_id, rid, idx, cnt, len, sb.peer_mac,
                            sb.peer_addr, $urandom, $urandom));
    endtask

    task automatic send_random_hello();
        logic [63:0] mac;
        logic [31:0] ip;
        logic [31:0] cn;
        logic [31:0] sn;
        logic [10:0] len;
        logic [5:0]  cnt;
        mac = sb.peer_mac;
        ip = sb.peer_addr;
        if (!sb.sess_open || $urandom_range(99) < 30)
        begin
            mac = {$urandom, $urandom};
            ip = $urandom;
        end
        cn = $urandom;
        sn = ($urandom_range(99) < 10) ? cn : $urandom;
        len = 11'd4;
        cnt = 6'd1;
        if ($urandom_range(99) < 8)
        begin
            if ($urandom_range(1))
                len = 11'($urandom);
            else
                cnt = 6'($urandom);
        end
        send_hello(mac, ip, cn, sn, len, cnt);
    endtask

    // one request split into fragments, mostly clean, sometimes damaged
    task automatic send_request_burst();
        int          cnt;
        int          n;
        int          j;
        int          tmp;
        int          lastmax;
        int          order [32];
        logic [7:0]  op;
        logic [15:0] rid;
        logic [10:0] len;
        logic [5:0]  c;
        logic [4:0]  idx;
        if (sb.last_answer_valid)
        begin
            if ($urandom_range(99) < 80)
                rid = sb.last_answer_id + 16'($urandom_range(1, 4));
            else
                rid = sb.last_answer_id + 16'($urandom_range(1, 32767));
        end
        else
            rid = 16'($urandom);
        tmp = $urandom_range(99);
        if (tmp < 85)
            cnt = $urandom_range(1, 5);
        else if (tmp < 92)
            cnt = $urandom_range(0, 32);
        else
            cnt = $urandom_range(0, 63);
        op = 8'($urandom);
        n = (cnt > 6) ? 6 : cnt;
        if (n == 0)
            n = 1;
        for (int k = 0; k < n; k++) order[k] = k;
        for (int k = n - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < n; k++)
        begin
            idx = 5'(order[k]);
            if (order[k] == cnt - 1)
            begin
                lastmax = BUFFER_BYTES - order[k] * FRAGMENT_PAYLOAD;
                if (lastmax > FRAGMENT_PAYLOAD)
                    lastmax = FRAGMENT_PAYLOAD;
                if (lastmax < 0)
                    lastmax = 0;
                len = 11'($urandom_range(0, lastmax));
            end
            else if ($urandom_range(99) < 90)
                len = 11'(FRAGMENT_PAYLOAD);
            else
                len = 11'($urandom_range(0, FRAGMENT_PAYLOAD));
            c = 6'(cnt);
            tmp = $urandom_range(99);
            if (tmp < 2)
                c = c + 6'd1;
            else if (tmp < 4)
                send_frag(op ^ 8'h01, rid, idx, c, len);
            else if (tmp < 6)
                idx = 5'($urandom);
            else if (tmp < 8)
                len = 11'($urandom_range(FRAGMENT_PAYLOAD + 1, 2047));
            else if (tmp < 11)
                send_frag(op, rid, idx, c, len);
            send_frag(op, rid, idx, c, len);
        end
    endtask

    task automatic send_old_id();
        logic [15:0] rid;
        case ($urandom_range(2))
            0: rid = sb.last_answer_id;
            1: rid = sb.last_answer_id - 16'($urandom_range(1, 32767));
            default: rid = sb.last_answer_id + 16'h8000;
        endcase
        send_frag(8'($urandom), rid, 5'($urandom), 6'($urandom_range(1, 5)),
                  11'($urandom_range(0, FRAGMENT_PAYLOAD)));
    endtask

    task automatic send_noise();
        req_t item;
        item.packet_valid = ($urandom_range(99) >= 20);
        item.opcode = ($urandom_range(99) < 20) ? sb.hello_op : 8'($urandom);
        item.session_tag = ($urandom_range(99) < 40) ? sb.sess_id : 16'($urandom);
        item.req_id = 16'($urandom);
        item.frag_index = 5'($urandom);
        item.frag_count = 6'($urandom);
        item.frag_length = 11'($urandom);
        item.peer_mac_port = ($urandom_range(99) < 40) ? sb.peer_mac : {$urandom, $urandom};
        item.peer_ip = ($urandom_range(99) < 40) ? sb.peer_addr : $urandom;
        item.peer_nonce = $urandom;
        item.local_nonce = $urandom;
        send_request(item);
    endtask

    task automatic run_directed();
        send_request(mk_req(1'b0, 8'hFF, 16'hFFFF, 16'hFFFF, 5'h1F, 6'h3F, 11'h7FF,
                            '1, '1, '1, '1));
        // nothing open yet
        send_request(mk_req(1'b1, 8'h22, 16'h1234, 16'h0001, 5'd0, 6'd1, 11'd4,
                            HOME_MAC, HOME_IP, '0, '0));
        send_hello(HOME_MAC, HOME_IP, 32'd1, 32'd2, 11'd5, 6'd1);
        send_hello(HOME_MAC, HOME_IP, 32'd1, 32'd2, 11'd4, 6'd2);
        // equal nonces force the session number to one
        send_hello('1, '1, '1, '1, 11'd4, 6'd1);
        send_hello(HOME_MAC, HOME_IP, 32'h0000_ABCD, 32'h0, 11'd4, 6'd1);
        send_request(mk_req(1'b1, 8'h22, sb.sess_id, 16'h0010, 5'd0, 6'd3, 11'd1024,
                            HOME_MAC, HOME_IP ^ 32'h1, '0, '0));
        send_request(mk_req(1'b1, 8'h22, sb.sess_id ^ 16'h0100, 16'h0010, 5'd0, 6'd3,
                            11'd1024, HOME_MAC, HOME_IP, '0, '0));
        send_frag(8'h22, 16'h0010, 5'd2, 6'd3, 11'd100);
        send_frag(8'h22, 16'h0010, 5'd0, 6'd3, 11'd1024);
        send_frag(8'h22, 16'h0010, 5'd1, 6'd4, 11'd1024);
        send_frag(8'h23, 16'h0010, 5'd1, 6'd3, 11'd1024);
        send_frag(8'h22, 16'h0010, 5'd1, 6'd3, 11'd1024);
        send_frag(8'h22, 16'h0010, 5'd0, 6'd3, 11'd1024);
        send_frag(8'h22, 16'h000F, 5'd0, 6'd3, 11'd1024);
        send_frag(8'h22, 16'h8010, 5'd0, 6'd3, 11'd1024);
        // zero count never completes
        send_frag(8'h30, 16'h0011, 5'd0, 6'd0, 11'd0);
        // stray index keeps the mask from matching
        send_frag(8'h31, 16'h0012, 5'd3, 6'd2, 11'd5);
        send_frag(8'h31, 16'h0012, 5'd0, 6'd2, 11'd1024);
        send_frag(8'h31, 16'h0012, 5'd1, 6'd2, 11'd10);
        send_frag(8'h32, 16'h0013, 5'd0, 6'd33, 11'd1024);
        send_frag(8'h33, 16'h0014, 5'd4, 6'd5, 11'd134);
        send_frag(8'h33, 16'h0014, 5'd4, 6'd5, 11'd133);
        // hello in the middle of an assembly
        send_hello(HOME_MAC, HOME_IP, 32'h5555_0000, 32'h0000_AAAA, 11'd4, 6'd1);
        for (int k = 0; k < 4; k++)
            send_frag(8'h33, 16'h0014, 5'(k), 6'd5, 11'd1024);
    endtask

    task automatic run_random(input int target);
        int stop_at;
        int pause_at;
        int r;
        stop_at = items_sent + target;
        pause_at = items_sent + target / 2;
        while (items_sent < stop_at)
        begin
            if (pause_at != 0 && items_sent >= pause_at)
            begin
                wait_results_drained();
                pause_at = 0;
            end
            r = $urandom_range(99);
            if (!sb.sess_open || r < 10)
                send_random_hello();
            else if (r < 75)
                send_request_burst();
            else if (r < 85)
                send_old_id();
            else
                send_noise();
        end
    endtask

    initial
    begin
        logic [7:0] opcode_plan [8];
        opcode_plan = '{8'h00, 8'hFF, 8'($urandom), 8'h01, 8'($urandom), 8'hFF, 8'h00,
                        8'($urandom)};
        sb = new();
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        items_sent = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_directed();
        for (int ph = 0; ph < 8; ph++)
        begin
            write_hello_opcode(opcode_plan[ph]);
            case (ph % 4)
                0:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 74;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 74;
                end
                default:
                begin
                    src_idle_pct = 35;
                    sink_stall_pct = 35;
                end
            endcase
            run_random(PHASE_ITEMS);
        end
        wait_results_drained();
        repeat (6) @(negedge clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
